/* src/nrmc_pkg.sv */
`timescale 1ns / 1ps
package nrmc_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_END   = 2'd1,
        KIND_COMMA = 2'd2,
        KIND_CHAR  = 2'd3
    } kind_t;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       too_long;
        logic       is_digit;
        logic [3:0] digit;
        logic       hex_ok;
        logic [3:0] hex_val;
    } item_t;

    // Finished sentence state handed to the output stage.
    typedef struct packed {
        logic        too_long;
        logic        bad_digit;
        logic        header_match;
        logic [3:0]  field_index;
        logic        fmt_bad;
        logic [6:0]  char_in_field;
        logic        after_star;
        logic [7:0]  mode_char;
        logic [7:0]  received_check;
        logic [7:0]  running_xor;
        logic [12:0] minute;
        logic [26:0] lat;
        logic [27:0] lon;
        logic        south;
        logic        west;
        logic [6:0]  dd;
        logic [6:0]  mm;
        logic [6:0]  yy;
    } snap_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S_UP   = 8'h53;
    localparam logic [7:0] CH_S_LO   = 8'h73;
    localparam logic [7:0] CH_W_UP   = 8'h57;
    localparam logic [7:0] CH_W_LO   = 8'h77;

    localparam logic [3:0] FIELD_HEADER = 4'd0;
    localparam logic [3:0] FIELD_TIME   = 4'd1;
    localparam logic [3:0] FIELD_LAT    = 4'd3;
    localparam logic [3:0] FIELD_NS     = 4'd4;
    localparam logic [3:0] FIELD_LON    = 4'd5;
    localparam logic [3:0] FIELD_EW     = 4'd6;
    localparam logic [3:0] FIELD_DATE   = 4'd9;
    localparam logic [3:0] FIELD_CHECK  = 4'd12;
    localparam logic [3:0] FIELD_MAX    = 4'd15;

    localparam logic [28:0] LAT_LIMIT = 29'd90000000;
    localparam logic [28:0] LON_LIMIT = 29'd180000000;

    localparam logic [2:0] FAIL_OK       = 3'd0;
    localparam logic [2:0] FAIL_NOT_RMC  = 3'd1;
    localparam logic [2:0] FAIL_FIELDS   = 3'd2;
    localparam logic [2:0] FAIL_FORMAT   = 3'd3;
    localparam logic [2:0] FAIL_MODE_N   = 3'd4;
    localparam logic [2:0] FAIL_CHECKSUM = 3'd5;
    localparam logic [2:0] FAIL_DIGIT    = 3'd6;
    localparam logic [2:0] FAIL_LONG     = 3'd7;

    function automatic logic [7:0] header_char(input logic [2:0] p);
        case (p)
            3'd0:    header_char = 8'h24;
            3'd1:    header_char = 8'h47;
            3'd2:    header_char = 8'h50;
            3'd3:    header_char = 8'h52;
            3'd4:    header_char = 8'h4D;
            3'd5:    header_char = 8'h43;
            default: header_char = 8'h00;
        endcase
    endfunction

    function automatic logic [9:0] minute_weight(input logic [1:0] p);
        case (p)
            2'd0:    minute_weight = 10'd600;
            2'd1:    minute_weight = 10'd60;
            2'd2:    minute_weight = 10'd10;
            default: minute_weight = 10'd1;
        endcase
    endfunction

    function automatic logic [19:0] pow10(input logic [2:0] k);
        case (k)
            3'd0:    pow10 = 20'd1;
            3'd1:    pow10 = 20'd10;
            3'd2:    pow10 = 20'd100;
            3'd3:    pow10 = 20'd1000;
            3'd4:    pow10 = 20'd10000;
            3'd5:    pow10 = 20'd100000;
            default: pow10 = 20'd1000000;
        endcase
    endfunction

    // Days of the months before month m, February counted as 28 days.
    function automatic logic [8:0] month_base(input logic [3:0] m);
        case (m)
            4'd2:    month_base = 9'd31;
            4'd3:    month_base = 9'd59;
            4'd4:    month_base = 9'd90;
            4'd5:    month_base = 9'd120;
            4'd6:    month_base = 9'd151;
            4'd7:    month_base = 9'd181;
            4'd8:    month_base = 9'd212;
            4'd9:    month_base = 9'd243;
            4'd10:   month_base = 9'd273;
            4'd11:   month_base = 9'd304;
            4'd12:   month_base = 9'd334;
            default: month_base = 9'd0;
        endcase
    endfunction

endpackage

/* src/nrmc_front.sv */
`timescale 1ns / 1ps
module nrmc_front #(
    parameter int MAX_SENTENCE_LEN = 100
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    output logic           q_valid,
    input  logic           q_ready,
    output nrmc_pkg::item_t q_item
);
    localparam int LW = $clog2(MAX_SENTENCE_LEN + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_SENTENCE_LEN);

    logic          in_sentence_reg, in_sentence_next;
    logic [LW-1:0] len_reg, len_next;
    logic          is_dollar, take;

    assign s_tready  = q_ready;
    assign is_dollar = (s_tdata == nrmc_pkg::CH_DOLLAR);
    assign take      = s_tvalid && q_ready;
    // Bytes outside a sentence are dropped here and never reach the back.
    assign q_valid   = s_tvalid && (is_dollar || in_sentence_reg);

    always_comb begin
        q_item          = '0;
        q_item.ch       = s_tdata;
        q_item.is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
        q_item.digit    = s_tdata[3:0];
        q_item.too_long = !is_dollar && (len_reg >= LEN_MAX);
        if (is_dollar) begin
            q_item.kind = nrmc_pkg::KIND_START;
        end else if (s_tdata == nrmc_pkg::CH_CR) begin
            q_item.kind = nrmc_pkg::KIND_END;
        end else if (s_tdata == nrmc_pkg::CH_COMMA) begin
            q_item.kind = nrmc_pkg::KIND_COMMA;
        end else begin
            q_item.kind = nrmc_pkg::KIND_CHAR;
        end
        if (q_item.is_digit) begin
            q_item.hex_ok  = 1'b1;
            q_item.hex_val = s_tdata[3:0];
        end else if (((s_tdata >= 8'h61) && (s_tdata <= 8'h66))
                     || ((s_tdata >= 8'h41) && (s_tdata <= 8'h46))) begin
            q_item.hex_ok  = 1'b1;
            q_item.hex_val = s_tdata[3:0] + 4'd9;
        end
    end

    always_comb begin
        in_sentence_next = in_sentence_reg;
        len_next         = len_reg;
        if (take) begin
            if (is_dollar) begin
                in_sentence_next = 1'b1;
                len_next         = LW'(1);
            end else if (in_sentence_reg) begin
                if (len_reg < LEN_MAX) len_next = len_reg + LW'(1);
                if (s_tdata == nrmc_pkg::CH_CR) in_sentence_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            len_reg         <= '0;
        end else begin
            in_sentence_reg <= in_sentence_next;
            len_reg         <= len_next;
        end
    end
endmodule

/* src/nrmc_queue.sv */
`timescale 1ns / 1ps
module nrmc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  nrmc_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output nrmc_pkg::item_t rd_item
);
    nrmc_pkg::item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_next;
        end
    end
endmodule

/* src/nrmc_back.sv */
`timescale 1ns / 1ps
module nrmc_back #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  nrmc_pkg::item_t q_item,
    output logic            snap_valid,
    input  logic            snap_ready,
    output nrmc_pkg::snap_t snap
);
    localparam int FW = $clog2(FRACTION_DIGITS + 1);
    localparam logic [FW-1:0] FD = FW'(FRACTION_DIGITS);

    logic [3:0]  fi_reg, fi_next;
    logic [6:0]  cif_reg, cif_next;
    logic [7:0]  xor_reg, xor_next;
    logic        star_reg, star_next;
    logic        hdr_reg, hdr_next;
    logic [12:0] min_reg, min_next;
    logic [26:0] lat_reg, lat_next;
    logic [27:0] lon_reg, lon_next;
    logic [FW-1:0] fc_reg, fc_next;
    logic        sp_reg, sp_next;
    logic        south_reg, south_next;
    logic        west_reg, west_next;
    logic [6:0]  date_reg [3];
    logic [6:0]  date_next [3];
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  rc_reg, rc_next;
    logic        long_reg, long_next;
    logic        bad_reg, bad_next;
    logic        fmt_reg, fmt_next;
    logic        sv_reg, sv_next;
    nrmc_pkg::snap_t snap_reg, snap_next;

    logic        take;
    logic [47:0] pad_prod;
    logic [28:0] pad_acc, pad_lim, pad_val;
    logic [28:0] coord_acc, coord_lim, coord_val;
    logic        coord_push;
    logic [32:0] coord_sum;
    logic        fin_hdr, fin_bad;
    logic [26:0] fin_lat;
    logic [27:0] fin_lon;
    logic [1:0]  dsel;
    logic [10:0] dsum;
    logic [7:0]  c;
    logic [6:0]  p;

    assign q_ready    = !((q_item.kind == nrmc_pkg::KIND_END) && sv_reg && !snap_ready);
    assign take       = q_valid && q_ready;
    assign snap_valid = sv_reg;
    assign snap       = snap_reg;
    assign c          = q_item.ch;
    assign p          = cif_reg;

    // Missing fraction digits: one multiply by a power of ten, then clamp.
    always_comb begin
        pad_acc  = (fi_reg == nrmc_pkg::FIELD_LAT) ? {2'b00, lat_reg} : {1'b0, lon_reg};
        pad_lim  = (fi_reg == nrmc_pkg::FIELD_LAT) ? nrmc_pkg::LAT_LIMIT
                                                   : nrmc_pkg::LON_LIMIT;
        pad_prod = 48'(pad_acc) * 48'(nrmc_pkg::pow10(3'(FD - fc_reg)));
        pad_val  = (pad_prod > 48'(pad_lim)) ? pad_lim : pad_prod[28:0];
    end

    always_comb begin
        fin_hdr = hdr_reg && !((fi_reg == nrmc_pkg::FIELD_HEADER) && (cif_reg != 7'd6));
        fin_bad = bad_reg || ((fi_reg == nrmc_pkg::FIELD_TIME) && (cif_reg < 7'd4))
                          || ((fi_reg == nrmc_pkg::FIELD_DATE) && (cif_reg < 7'd6));
        fin_lat = (fi_reg == nrmc_pkg::FIELD_LAT) ? pad_val[26:0] : lat_reg;
        fin_lon = (fi_reg == nrmc_pkg::FIELD_LON) ? pad_val[27:0] : lon_reg;
    end

    // Shared coordinate digit accumulator for the latitude and longitude fields.
    always_comb begin
        coord_acc  = (fi_reg == nrmc_pkg::FIELD_LAT) ? {2'b00, lat_reg} : {1'b0, lon_reg};
        coord_lim  = (fi_reg == nrmc_pkg::FIELD_LAT) ? nrmc_pkg::LAT_LIMIT
                                                     : nrmc_pkg::LON_LIMIT;
        coord_sum  = {1'b0, coord_acc, 3'b000} + {3'b000, coord_acc, 1'b0}
                   + {29'd0, q_item.digit};
        coord_val  = (coord_sum > 33'(coord_lim)) ? coord_lim : coord_sum[28:0];
        coord_push = q_item.is_digit && (!sp_reg || (fc_reg < FD));
    end

    always_comb begin
        dsel = p[2:1];
        dsum = {4'd0, date_reg[dsel]} * 11'd10 + {7'd0, q_item.digit};
    end

    always_comb begin
        fi_next    = fi_reg;    cif_next   = cif_reg;  xor_next  = xor_reg;
        star_next  = star_reg;  hdr_next   = hdr_reg;  min_next  = min_reg;
        lat_next   = lat_reg;   lon_next   = lon_reg;  fc_next   = fc_reg;
        sp_next    = sp_reg;    south_next = south_reg; west_next = west_reg;
        mode_next  = mode_reg;  rc_next    = rc_reg;   long_next = long_reg;
        bad_next   = bad_reg;   fmt_next   = fmt_reg;
        for (int i = 0; i < 3; i++) date_next[i] = date_reg[i];
        sv_next    = sv_reg && !snap_ready;
        snap_next  = snap_reg;

        if (take) begin
            if (q_item.too_long) long_next = 1'b1;
            case (q_item.kind)
                nrmc_pkg::KIND_START: begin
                    fi_next = '0; cif_next = 7'd1; xor_next = '0; star_next = 1'b0;
                    hdr_next = 1'b1; min_next = '0; lat_next = '0; lon_next = '0;
                    fc_next = '0; sp_next = 1'b0; south_next = 1'b0; west_next = 1'b0;
                    mode_next = '0; rc_next = '0; long_next = 1'b0; bad_next = 1'b0;
                    fmt_next = 1'b0;
                    for (int i = 0; i < 3; i++) date_next[i] = '0;
                end
                nrmc_pkg::KIND_COMMA: begin
                    hdr_next = fin_hdr; bad_next = fin_bad;
                    lat_next = fin_lat; lon_next = fin_lon;
                    if (!star_reg) xor_next = xor_reg ^ nrmc_pkg::CH_COMMA;
                    if (fi_reg < nrmc_pkg::FIELD_MAX) fi_next = fi_reg + 4'd1;
                    cif_next = '0; fc_next = '0; sp_next = 1'b0;
                end
                nrmc_pkg::KIND_END: begin
                    sv_next                  = 1'b1;
                    snap_next.too_long       = long_reg || q_item.too_long;
                    snap_next.bad_digit      = fin_bad;
                    snap_next.header_match   = fin_hdr;
                    snap_next.field_index    = fi_reg;
                    snap_next.fmt_bad        = fmt_reg;
                    snap_next.char_in_field  = cif_reg;
                    snap_next.after_star     = star_reg;
                    snap_next.mode_char      = mode_reg;
                    snap_next.received_check = rc_reg;
                    snap_next.running_xor    = xor_reg;
                    snap_next.minute         = min_reg;
                    snap_next.lat            = fin_lat;
                    snap_next.lon            = fin_lon;
                    snap_next.south          = south_reg;
                    snap_next.west           = west_reg;
                    snap_next.dd             = date_reg[0];
                    snap_next.mm             = date_reg[1];
                    snap_next.yy             = date_reg[2];
                end
                default: begin
                    if (c == nrmc_pkg::CH_STAR) begin
                        if (!((fi_reg == nrmc_pkg::FIELD_CHECK) && (p == 7'd1)))
                            fmt_next = 1'b1;
                        star_next = 1'b1;
                    end else if (!star_reg) begin
                        xor_next = xor_reg ^ c;
                    end
                    case (fi_reg)
                        nrmc_pkg::FIELD_HEADER: begin
                            if ((p >= 7'd6) || (nrmc_pkg::header_char(p[2:0]) != c))
                                hdr_next = 1'b0;
                        end
                        nrmc_pkg::FIELD_TIME: begin
                            if (p < 7'd4) begin
                                if (q_item.is_digit)
                                    min_next = min_reg
                                             + 13'(nrmc_pkg::minute_weight(p[1:0]))
                                             * 13'(q_item.digit);
                                else
                                    bad_next = 1'b1;
                            end
                        end
                        nrmc_pkg::FIELD_LAT, nrmc_pkg::FIELD_LON: begin
                            if (q_item.is_digit) begin
                                if (coord_push) begin
                                    if (fi_reg == nrmc_pkg::FIELD_LAT)
                                        lat_next = coord_val[26:0];
                                    else
                                        lon_next = coord_val[27:0];
                                    if (sp_reg) fc_next = fc_reg + FW'(1);
                                end
                            end else if ((c == nrmc_pkg::CH_POINT) && !sp_reg) begin
                                sp_next = 1'b1;
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        nrmc_pkg::FIELD_NS: begin
                            if ((p == 7'd0) && ((c == nrmc_pkg::CH_S_UP) ||
                                                (c == nrmc_pkg::CH_S_LO)))
                                south_next = 1'b1;
                        end
                        nrmc_pkg::FIELD_EW: begin
                            if ((p == 7'd0) && ((c == nrmc_pkg::CH_W_UP) ||
                                                (c == nrmc_pkg::CH_W_LO)))
                                west_next = 1'b1;
                        end
                        nrmc_pkg::FIELD_DATE: begin
                            if (p < 7'd6) begin
                                if (q_item.is_digit) date_next[dsel] = dsum[6:0];
                                else bad_next = 1'b1;
                            end
                        end
                        nrmc_pkg::FIELD_CHECK: begin
                            if (p == 7'd0) begin
                                mode_next = c;
                            end else if (p == 7'd1) begin
                                if (c != nrmc_pkg::CH_STAR) fmt_next = 1'b1;
                            end else if (p < 7'd4) begin
                                if (!q_item.hex_ok) fmt_next = 1'b1;
                                else rc_next = {rc_reg[3:0], q_item.hex_val};
                            end else begin
                                fmt_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (cif_reg < 7'd127) cif_next = cif_reg + 7'd1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
        for (int i = 0; i < 3; i++) date_reg[i] <= date_next[i];
        min_reg  <= min_next;
        lat_reg  <= lat_next;
        lon_reg  <= lon_next;
        mode_reg <= mode_next;
        rc_reg   <= rc_next;
        xor_reg  <= xor_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fi_reg <= '0; cif_reg <= '0; star_reg <= 1'b0; hdr_reg <= 1'b1;
            fc_reg <= '0; sp_reg <= 1'b0; south_reg <= 1'b0; west_reg <= 1'b0;
            long_reg <= 1'b0; bad_reg <= 1'b0; fmt_reg <= 1'b0; sv_reg <= 1'b0;
        end else begin
            fi_reg <= fi_next; cif_reg <= cif_next; star_reg <= star_next;
            hdr_reg <= hdr_next; fc_reg <= fc_next; sp_reg <= sp_next;
            south_reg <= south_next; west_reg <= west_next; long_reg <= long_next;
            bad_reg <= bad_next; fmt_reg <= fmt_next; sv_reg <= sv_next;
        end
    end
endmodule

/* src/nrmc_emit.sv */
`timescale 1ns / 1ps
module nrmc_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            snap_valid,
    output logic            snap_ready,
    input  nrmc_pkg::snap_t snap,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [87:0]     m_tdata
);
    logic        ov_reg;
    logic [82:0] data_reg, data_next;
    logic [2:0]  code;
    logic [8:0]  doy;
    logic [27:0] lat;
    logic [28:0] lon;

    assign snap_ready = !ov_reg || m_tready;
    assign m_tvalid   = ov_reg;
    assign m_tdata    = {5'd0, data_reg};

    always_comb begin
        if (snap.too_long)                             code = nrmc_pkg::FAIL_LONG;
        else if (!snap.header_match)                   code = nrmc_pkg::FAIL_NOT_RMC;
        else if (snap.field_index != nrmc_pkg::FIELD_CHECK) code = nrmc_pkg::FAIL_FIELDS;
        else if (snap.fmt_bad || (snap.char_in_field != 7'd4) || !snap.after_star)
                                                       code = nrmc_pkg::FAIL_FORMAT;
        else if (snap.mode_char == nrmc_pkg::CH_N)     code = nrmc_pkg::FAIL_MODE_N;
        else if (snap.received_check != snap.running_xor) code = nrmc_pkg::FAIL_CHECKSUM;
        else if (snap.bad_digit)                       code = nrmc_pkg::FAIL_DIGIT;
        else                                           code = nrmc_pkg::FAIL_OK;

        doy = {2'b00, snap.dd};
        if ((snap.mm >= 7'd1) && (snap.mm <= 7'd12)) begin
            doy = doy + nrmc_pkg::month_base(snap.mm[3:0]);
            // Leap day counts from March on when the year is a multiple of four.
            if ((snap.mm >= 7'd3) && (snap.yy[1:0] == 2'b00)) doy = doy + 9'd1;
        end
        lat = snap.south ? (28'd0 - {1'b0, snap.lat}) : {1'b0, snap.lat};
        lon = snap.west  ? (29'd0 - {1'b0, snap.lon}) : {1'b0, snap.lon};

        data_next = '0;
        data_next[3:1] = code;
        if (code == nrmc_pkg::FAIL_OK) begin
            data_next[0]     = 1'b1;
            data_next[16:4]  = snap.minute;
            data_next[44:17] = lat;
            data_next[73:45] = lon;
            data_next[82:74] = doy;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (snap_ready) begin
            ov_reg <= snap_valid;
        end
    end
endmodule

/* src/nmea_rmc_sentence_parser.sv */
`timescale 1ns / 1ps
// A closing carriage return passes the queue and the snapshot register; m_tvalid is registered.
// Throughput: one byte per cycle; a carriage return waits only while two results are still
// held, in the snapshot register and in the output register.
// Reset: synchronous, active low on aresetn; it empties the queue and the output, and the
// parser starts outside a sentence.
module nmea_rmc_sentence_parser #(
    parameter int MAX_SENTENCE_LEN = 100,
    parameter int FRACTION_DIGITS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte [7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // sentence_ok [0], fail_code [3:1], minute_of_day [16:4], latitude_scaled [44:17],
    // longitude_scaled [73:45], ordinal_day [82:74], zero fill [87:83]
    output logic [87:0] m_tdata
);
    // The front tracks sentence framing and length and classifies each byte.
    // The back holds the field parser state and takes one queued byte per cycle; a CR can stall.
    // The output stage ranks the failure checks and converts the finished values.
    logic            fq_valid, fq_ready, bq_valid, bq_ready;
    nrmc_pkg::item_t fq_item, bq_item;
    logic            snap_valid, snap_ready;
    nrmc_pkg::snap_t snap;

    nrmc_front #(.MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    nrmc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_item(bq_item)
    );

    nrmc_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_item(bq_item),
        .snap_valid(snap_valid), .snap_ready(snap_ready), .snap(snap)
    );

    nrmc_emit u_emit (
        .aclk(aclk), .aresetn(aresetn),
        .snap_valid(snap_valid), .snap_ready(snap_ready), .snap(snap),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule

/* test/nmea_rmc_checker.sv */
`timescale 1ns / 1ps
module nmea_rmc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    localparam int MAX_LEN = 100;
    localparam int FRAC_DIGITS = 4;

    logic [87:0] fix_queue[$];

    logic        busy, star_seen, hdr_ok, point_seen, south, west, fmt_err;
    logic [3:0]  fld;
    logic [6:0]  pos, length;
    logic [7:0]  xsum, mode, rx_check;
    logic [2:0]  err, frac_cnt;
    logic [31:0] minute, lat, lon;
    logic [6:0]  dd, mm, yy;

    task automatic clear_sentence();
        fld = 0; pos = 0; length = 0; xsum = 0; star_seen = 0; hdr_ok = 1;
        minute = 0; lat = 0; lon = 0; dd = 0; mm = 0; yy = 0;
        frac_cnt = 0; point_seen = 0; south = 0; west = 0;
        mode = 0; rx_check = 0; err = nrmc_pkg::FAIL_OK; fmt_err = 0;
    endtask

    function automatic logic [31:0] push_digit(logic [31:0] acc, int d, logic [31:0] lim);
        longint v;
        v = longint'(acc) * 10 + d;
        return (v > lim) ? lim : v[31:0];
    endfunction

    task automatic coord_char(inout logic [31:0] acc, input logic [31:0] lim,
                              input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            if (!point_seen) begin
                acc = push_digit(acc, c - "0", lim);
            end else if (frac_cnt < FRAC_DIGITS) begin
                acc = push_digit(acc, c - "0", lim);
                frac_cnt++;
            end
        end else if (c == nrmc_pkg::CH_POINT && !point_seen) begin
            point_seen = 1;
        end else if (err == nrmc_pkg::FAIL_OK) begin
            err = nrmc_pkg::FAIL_DIGIT;
        end
    endtask

    task automatic close_field();
        case (fld)
            nrmc_pkg::FIELD_HEADER: if (pos != 6) hdr_ok = 0;
            nrmc_pkg::FIELD_TIME:
                if (pos < 4 && err == nrmc_pkg::FAIL_OK) err = nrmc_pkg::FAIL_DIGIT;
            nrmc_pkg::FIELD_LAT: while (frac_cnt < FRAC_DIGITS) begin
                lat = push_digit(lat, 0, nrmc_pkg::LAT_LIMIT); frac_cnt++;
            end
            nrmc_pkg::FIELD_LON: while (frac_cnt < FRAC_DIGITS) begin
                lon = push_digit(lon, 0, nrmc_pkg::LON_LIMIT); frac_cnt++;
            end
            nrmc_pkg::FIELD_DATE:
                if (pos < 6 && err == nrmc_pkg::FAIL_OK) err = nrmc_pkg::FAIL_DIGIT;
            default: ;
        endcase
    endtask

    function automatic int hex_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic field_char(logic [7:0] c);
        logic dig;
        int h;
        dig = (c >= "0" && c <= "9");
        if (c == nrmc_pkg::CH_STAR) begin
            if (!(fld == nrmc_pkg::FIELD_CHECK && pos == 1)) fmt_err = 1;
            star_seen = 1;
        end else if (!star_seen) begin
            xsum ^= c;
        end
        case (fld)
            nrmc_pkg::FIELD_HEADER:
                if (pos >= 6 || nrmc_pkg::header_char(pos[2:0]) != c) hdr_ok = 0;
            nrmc_pkg::FIELD_TIME: if (pos < 4) begin
                if (dig) minute += nrmc_pkg::minute_weight(pos[1:0]) * (c - "0");
                else if (err == nrmc_pkg::FAIL_OK) err = nrmc_pkg::FAIL_DIGIT;
            end
            nrmc_pkg::FIELD_LAT: coord_char(lat, nrmc_pkg::LAT_LIMIT, c);
            nrmc_pkg::FIELD_NS:
                if (pos == 0 && (c == nrmc_pkg::CH_S_UP || c == nrmc_pkg::CH_S_LO)) south = 1;
            nrmc_pkg::FIELD_LON: coord_char(lon, nrmc_pkg::LON_LIMIT, c);
            nrmc_pkg::FIELD_EW:
                if (pos == 0 && (c == nrmc_pkg::CH_W_UP || c == nrmc_pkg::CH_W_LO)) west = 1;
            nrmc_pkg::FIELD_DATE: if (pos < 6) begin
                if (dig) begin
                    case (pos / 2)
                        0: dd = dd * 10 + (c - "0");
                        1: mm = mm * 10 + (c - "0");
                        default: yy = yy * 10 + (c - "0");
                    endcase
                end else if (err == nrmc_pkg::FAIL_OK) begin
                    err = nrmc_pkg::FAIL_DIGIT;
                end
            end
            nrmc_pkg::FIELD_CHECK: begin
                if (pos == 0) mode = c;
                else if (pos == 1) begin
                    if (c != nrmc_pkg::CH_STAR) fmt_err = 1;
                end else if (pos < 4) begin
                    h = hex_of(c);
                    if (h < 0) fmt_err = 1;
                    else rx_check = {rx_check[3:0], 4'(h)};
                end else fmt_err = 1;
            end
            default: ;
        endcase
        if (pos < 127) pos++;
    endtask

    function automatic logic [87:0] sentence_fix();
        logic [2:0]  code;
        logic [8:0]  doy;
        logic [27:0] lat_s;
        logic [28:0] lon_s;
        if (err == nrmc_pkg::FAIL_LONG) code = nrmc_pkg::FAIL_LONG;
        else if (!hdr_ok) code = nrmc_pkg::FAIL_NOT_RMC;
        else if (fld != nrmc_pkg::FIELD_CHECK) code = nrmc_pkg::FAIL_FIELDS;
        else if (fmt_err || pos != 4 || !star_seen) code = nrmc_pkg::FAIL_FORMAT;
        else if (mode == nrmc_pkg::CH_N) code = nrmc_pkg::FAIL_MODE_N;
        else if (rx_check != xsum) code = nrmc_pkg::FAIL_CHECKSUM;
        else if (err == nrmc_pkg::FAIL_DIGIT) code = nrmc_pkg::FAIL_DIGIT;
        else code = nrmc_pkg::FAIL_OK;
        if (code != nrmc_pkg::FAIL_OK) return {85'd0, code} << 1;
        doy = {2'b00, dd};
        if (mm >= 1 && mm <= 12) begin
            doy += nrmc_pkg::month_base(mm[3:0]);
            if (mm >= 3 && yy % 4 == 0) doy += 1;
        end
        lat_s = south ? -lat[27:0] : lat[27:0];
        lon_s = west ? -lon[28:0] : lon[28:0];
        return {5'd0, doy, lon_s, lat_s, minute[12:0], code, 1'b1};
    endfunction

    task automatic take_byte(logic [7:0] c);
        if (c == nrmc_pkg::CH_DOLLAR) begin
            clear_sentence();
            busy = 1; pos = 1; length = 1;
        end else if (busy) begin
            if (length >= MAX_LEN) err = nrmc_pkg::FAIL_LONG;
            else length++;
            if (c == nrmc_pkg::CH_CR) begin
                close_field();
                busy = 0;
                fix_queue.push_back(sentence_fix());
            end else if (c == nrmc_pkg::CH_COMMA) begin
                close_field();
                if (!star_seen) xsum ^= c;
                if (fld < nrmc_pkg::FIELD_MAX) fld++;
                pos = 0; frac_cnt = 0; point_seen = 0;
            end else begin
                field_char(c);
            end
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        busy = 0;
        clear_sentence();
    end

    always @(posedge aclk) begin
        logic [87:0] want;
        if (!aresetn) begin
            busy = 0;
            clear_sentence();
            fix_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (fix_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = fix_queue.pop_front();
                    if (want[0] !== m_tdata[0] || want[3:1] !== m_tdata[3:1]
                        || want[16:4] !== m_tdata[16:4] || want[44:17] !== m_tdata[44:17]
                        || want[73:45] !== m_tdata[73:45] || want[82:74] !== m_tdata[82:74]
                        || want[87:83] !== m_tdata[87:83]) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h actual %h", want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) take_byte(s_tdata);
        end
        pending = fix_queue.size();
    end
endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Drives NMEA byte streams into the RMC parser: a few hand-built sentences covering each
// failure code, then mostly well-formed RMC sentences with random content and random damage,
// mixed with stray noise bytes. A checker module beside the block predicts every result.
module testbench;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    int          fail_count, pending;
    int          cycle_count = 0;
    bit          calm = 0;     // When set, neither side idles.
    int          items_sent = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    nmea_rmc_sentence_parser uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    nmea_rmc_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // The receiver stalls on its own schedule, decided at each falling edge.
    always @(negedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end

    // The watchdog: the slowest correct run is far below this bound.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("nmea_rmc_sentence_parser verification failed");
            $finish;
        end
    end

    // Offer one byte and hold it until the transfer completes. tvalid stays high after
    // the transfer; the next byte or a pause in the stream decides its next value.
    task automatic send_byte(logic [7:0] b);
        while (!calm && $urandom_range(99) < 37) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    function automatic string hex2(logic [7:0] v);
        return $sformatf("%02X", v);
    endfunction

    function automatic logic [7:0] xor_of(string body);
        logic [7:0] x = 0;
        foreach (body[i]) x ^= body[i];
        return x;
    endfunction

    // A full sentence with a correct checksum; lower selects lowercase hex digits.
    task automatic send_sentence(string body, bit lower);
        string ck;
        ck = hex2(xor_of(body));
        if (lower) ck = ck.tolower();
        send_text({"$", body, "*", ck, "\r"});
    endtask

    function automatic string digits(int n, int hi);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(hi)))};
        return s;
    endfunction

    function automatic string coord(int whole);
        string s;
        s = digits(whole, 9);
        case ($urandom_range(5))
            0: s = "";
            1: s = {s, ".", digits($urandom_range(6), 9)};
            2: s = {s, "."};
            default: s = {s, ".", digits(4, 9)};
        endcase
        if ($urandom_range(19) == 0) s = {s, "x"};
        if ($urandom_range(29) == 0) s = {s, ".1"};
        return s;
    endfunction

    function automatic string rand_text(int n);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
        return s;
    endfunction

    // A random RMC body; most are sound, some carry damage of one or more kinds.
    function automatic string rand_body();
        string f[13];
        string s;
        int dmg;
        f[0] = "GPRMC";
        f[1] = {digits(2, 5), digits(4, 9), ($urandom_range(1) ? ".00" : "")};
        f[2] = $urandom_range(1) ? "A" : "V";
        f[3] = coord(4);
        f[4] = ($urandom_range(3) == 0) ? "" : string'(8'($urandom_range(1) ? "N" : "s"));
        f[5] = coord(5);
        f[6] = ($urandom_range(3) == 0) ? "" : string'(8'($urandom_range(1) ? "E" : "w"));
        f[7] = digits($urandom_range(3), 9);
        f[8] = digits($urandom_range(3), 9);
        f[9] = {digits(1, 3), digits(1, 9), digits(1, 1), digits(1, 9), digits(2, 9)};
        f[10] = "";
        f[11] = "";
        f[12] = string'(8'($urandom_range(3) == 0 ? "N" : "A"));
        dmg = $urandom_range(19);
        case (dmg)
            0: f[0] = "GPRMB";
            1: f[1] = digits($urandom_range(3), 9);
            2: f[9] = "12a456";
            3: f[7] = "1*2";
            4: f[0] = "GPRMCX";
            default: ;
        endcase
        s = f[0];
        for (int i = 1; i < 12; i++) s = {s, ",", f[i]};
        if (dmg == 5) s = {s, ",x"};
        if (dmg == 6) s = s.substr(0, s.len() - 3);
        return {s, ",", f[12]};
    endfunction

    task automatic wait_drained();
        s_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        string b;
        repeat (11) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: a good fix, lowercase check digits, every failure path.
        calm = 1;
        send_text("junk\r");
        send_sentence("GPRMC,235959,A,9000.0000,S,18000.0000,W,,,311224,,,A", 0);
        send_sentence("GPRMC,000000,A,4916.45,N,12311.12,E,,,010100,,,D", 1);
        send_sentence("GPRMC,1234,A,9999.9999,n,99999.99999,e,,,291304,,,A", 0);
        send_sentence("GPRMB,1234,A,,,,,,,010100,,,A", 0);
        send_sentence("GPRMC,1234,A,,,,,,,010100,,A", 0);
        send_text("$GPRMC,1234,A,,,,,,,010100,,,A*zz\r");
        send_text("$GPRMC,1234,A,,,,,,,010100,,,A00\r");
        send_sentence("GPRMC,1234,A,,,,,,,010100,,,N", 0);
        send_text("$GPRMC,1234,A,,,,,,,010100,,,A*00\r");
        send_sentence("GPRMC,12x4,A,1.2.3,,,,,,0101,,,A", 0);
        send_text({"$GP$GPRMC,", rand_text(110), "\r"});
        send_text(string'({8'hFF, 8'h00, "$", 8'h80, 8'h7F, "\r"}));
        calm = 0;
        wait_drained();

        // Random: sentences with random damage and noise between them.
        while (items_sent < 1500) begin
            case ($urandom_range(15))
                0: send_text({"$", rand_text($urandom_range(40)), "\r"});
                1: for (int k = $urandom_range(5); k > 0; k--)
                       send_byte(8'($urandom_range(255)));
                2: begin
                    b = rand_body();
                    send_text({"$", b.substr(0, $urandom_range(b.len() - 1)), "\r"});
                end
                3: send_text({"$", rand_body(), "*", hex2(8'($urandom)), "\r"});
                default: send_sentence(rand_body(), $urandom_range(1));
            endcase
            if ($urandom_range(199) == 0) wait_drained();
            calm = (items_sent > 1000 && items_sent < 1250);
        end

        calm = 0;
        s_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("nmea_rmc_sentence_parser verification clean");
        end else begin
            $display("nmea_rmc_sentence_parser verification failed");
        end
        $finish;
    end
endmodule

/* sim.f */
src/nrmc_pkg.sv
src/nrmc_front.sv
src/nrmc_queue.sv
src/nrmc_back.sv
src/nrmc_emit.sv
src/nmea_rmc_sentence_parser.sv
test/nmea_rmc_checker.sv
test/testbench.sv
